>>> hdl/positional_list_engine_macros.svh
// Assertion macros for the positional list engine.
// Used by the top level; needs a signal named clock and one named reset in scope.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define PLE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define PLE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/ple_pkg.sv
// Shared types and constants for the positional list engine.
// No dependencies; used by every module of the block.
package ple_pkg;

   localparam int CAPACITY   = 64;
   localparam int ELEM_WIDTH = 32;
   localparam int IDX_WIDTH  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int POS_WIDTH  = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      OP_CLEAR  = 3'd0,
      OP_INSERT = 3'd1,
      OP_DELETE = 3'd2,
      OP_READ   = 3'd3,
      OP_LOCATE = 3'd4,
      OP_PRIOR  = 3'd5,
      OP_NEXT   = 3'd6
   } ple_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } ple_state_type;

   // Command broadcast to every cell of the row
   typedef struct packed {
      logic                  exec;       // execute phase: shift and compare
      logic                  shift_up;   // valid insert
      logic                  shift_down; // valid delete
      logic [POS_WIDTH-1:0]  pos;        // one-based target position
      logic [POS_WIDTH-1:0]  bound;      // last position that moves
      logic [POS_WIDTH-1:0]  search_lo;  // first position that may match
      logic [POS_WIDTH-1:0]  search_hi;  // last position that may match
      logic                  take_left;  // report predecessor, else successor
      logic [ELEM_WIDTH-1:0] value;      // insert value or search key
   } ple_cmd_type;

endpackage

>>> hdl/ple_cell.sv
// One list slot: holds an entry, shifts with its neighbors, flags a key match.
// Depends on ple_pkg.
module ple_cell (
   input  logic                           clock,
   input  logic [ple_pkg::IDX_WIDTH-1:0]  cell_index,
   input  ple_pkg::ple_cmd_type           cmd,
   input  logic [ple_pkg::ELEM_WIDTH-1:0] left_entry,
   input  logic [ple_pkg::ELEM_WIDTH-1:0] right_entry,
   input  logic                           first_hit,
   output logic [ple_pkg::ELEM_WIDTH-1:0] entry,
   output logic                           match,
   output logic [ple_pkg::ELEM_WIDTH-1:0] read_tap,
   output logic [ple_pkg::ELEM_WIDTH-1:0] near_tap,
   output logic [ple_pkg::POS_WIDTH-1:0]  pos_tap
);

   logic [ple_pkg::ELEM_WIDTH-1:0] entry_ff;
   logic [ple_pkg::ELEM_WIDTH-1:0] entry_in;
   logic                           match_ff;
   logic                           match_in;
   logic [ple_pkg::POS_WIDTH-1:0]  slot_pos;

   // One-based position of this slot
   assign slot_pos = ple_pkg::POS_WIDTH'(cell_index) + ple_pkg::POS_WIDTH'(1);

   // Load, shift up, shift down or hold
   always_comb begin
      entry_in = entry_ff;
      if (cmd.exec && cmd.shift_up) begin
         if (slot_pos == cmd.pos) begin
            entry_in = cmd.value;
         end else if (slot_pos > cmd.pos && slot_pos <= cmd.bound) begin
            entry_in = left_entry;
         end
      end else if (cmd.exec && cmd.shift_down) begin
         if (slot_pos >= cmd.pos && slot_pos <= cmd.bound) begin
            entry_in = right_entry;
         end
      end
   end

   // Compare against the key within the search window
   always_comb begin
      match_in = match_ff;
      if (cmd.exec) begin
         match_in = (entry_ff == cmd.value) && (slot_pos >= cmd.search_lo)
                    && (slot_pos <= cmd.search_hi);
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   // Taps that the row ORs together
   assign read_tap = (slot_pos == cmd.pos) ? entry_ff : '0;
   assign near_tap = first_hit ? (cmd.take_left ? left_entry : right_entry) : '0;
   assign pos_tap  = first_hit ? slot_pos : '0;
   assign entry    = entry_ff;
   assign match    = match_ff;

endmodule

>>> hdl/ple_pick.sv
// First-match picker: isolates the lowest set flag of the row.
// Depends on ple_pkg.
module ple_pick (
   input  logic [ple_pkg::CAPACITY-1:0] hits,
   output logic [ple_pkg::CAPACITY-1:0] first
);

   // Lowest set bit: flags AND their two's complement
   assign first = hits & (~hits + ple_pkg::CAPACITY'(1));

endmodule

>>> hdl/positional_list_engine.sv
// Positional list engine: a fixed-capacity ordered list of signed words
// with one-based positions, built as a row of cells.
//
// Request channel: drive req_func, req_position and req_value and raise
// start; the transfer happens at a clock edge where start is high and busy
// is low. Operations: clear, insert, delete, read, locate, predecessor and
// successor; code 7 changes nothing and reports failure.
// Result channel: rsp_strobe is high for exactly one cycle with rsp_ok,
// rsp_found_value, rsp_found_position and rsp_list_length. The receiver
// cannot hold results off; it must take the transfer in that cycle.
// Operation: the work is done in an execute step and then a result step,
// with busy high in both. The execute step shifts the row and registers a
// match flag in each cell; the result step picks the first match across
// the row and registers the result together with the result strobe. No new
// request is taken while busy is high; one can be taken in the strobe cycle.
// Reset: synchronous, active high; empties the list and drops busy. The
// entries themselves are not cleared; slots past the length are never read.
`include "positional_list_engine_macros.svh"

module positional_list_engine (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [2:0]                            req_func,
   input  logic [ple_pkg::POS_WIDTH-1:0]         req_position,
   input  logic signed [ple_pkg::ELEM_WIDTH-1:0] req_value,
   output logic                                  rsp_strobe,
   output logic                                  rsp_ok,
   output logic signed [ple_pkg::ELEM_WIDTH-1:0] rsp_found_value,
   output logic [ple_pkg::POS_WIDTH-1:0]         rsp_found_position,
   output logic [ple_pkg::POS_WIDTH-1:0]         rsp_list_length
);

   localparam int N = ple_pkg::CAPACITY;
   localparam int W = ple_pkg::ELEM_WIDTH;
   localparam int P = ple_pkg::POS_WIDTH;

   ple_pkg::ple_state_type state_ff, state_in;
   ple_pkg::ple_op_type    op_ff;
   logic [P-1:0]           pos_ff;
   logic [W-1:0]           value_ff;
   logic [P-1:0]           count_ff, count_in;
   logic                   ok_ff, ok_in;
   logic [W-1:0]           data_ff, data_in;
   logic                   rsp_strobe_ff;
   logic                   rsp_ok_ff, rsp_ok_in;
   logic [W-1:0]           rsp_value_ff, rsp_value_in;
   logic [P-1:0]           rsp_pos_ff, rsp_pos_in;

   logic                   accept;
   logic                   exec_phase;
   logic                   resp_phase;
   logic                   pos_nonzero;
   logic                   ins_ok, del_ok, rd_ok;
   logic [P:0]             count_ext;
   logic [P:0]             pos_ext;

   ple_pkg::ple_cmd_type   cmd;
   logic [N-1:0][W-1:0]    cell_entry;
   logic [N-1:0][W-1:0]    read_tap;
   logic [N-1:0][W-1:0]    near_tap;
   logic [N-1:0][P-1:0]    pos_tap;
   logic [N-1:0]           hits;
   logic [N-1:0]           first;
   logic [W-1:0]           read_any;
   logic [W-1:0]           near_any;
   logic [P-1:0]           pos_any;

   assign accept = start && !busy;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ple_pkg::ST_IDLE: if (accept) state_in = ple_pkg::ST_EXEC;
         ple_pkg::ST_EXEC: state_in = ple_pkg::ST_RESP;
         ple_pkg::ST_RESP: state_in = ple_pkg::ST_IDLE;
         default:          state_in = ple_pkg::ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      busy       = 1'b1;
      exec_phase = 1'b0;
      resp_phase = 1'b0;
      case (state_ff)
         ple_pkg::ST_IDLE: busy = 1'b0;
         ple_pkg::ST_EXEC: exec_phase = 1'b1;
         ple_pkg::ST_RESP: resp_phase = 1'b1;
         default:          busy = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ple_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Hold the request for the duration of the operation
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= ple_pkg::ple_op_type'(req_func);
         pos_ff   <= req_position;
         value_ff <= req_value;
      end
   end

   // Range checks
   assign count_ext   = {1'b0, count_ff};
   assign pos_ext     = {1'b0, pos_ff};
   assign pos_nonzero = (pos_ff != '0);
   assign ins_ok = (op_ff == ple_pkg::OP_INSERT) && pos_nonzero
                   && (pos_ext <= count_ext + (P + 1)'(1)) && (count_ext < (P + 1)'(N));
   assign del_ok = (op_ff == ple_pkg::OP_DELETE) && pos_nonzero && (pos_ff <= count_ff);
   assign rd_ok  = (op_ff == ple_pkg::OP_READ) && pos_nonzero && (pos_ff <= count_ff);

   // Command to the row
   always_comb begin
      cmd            = '0;
      cmd.exec       = exec_phase;
      cmd.shift_up   = ins_ok;
      cmd.shift_down = del_ok;
      cmd.pos        = pos_ff;
      cmd.value      = value_ff;
      cmd.take_left  = (op_ff == ple_pkg::OP_PRIOR);
      cmd.bound      = ins_ok ? count_ff + P'(1) : count_ff - P'(1);
      case (op_ff)
         ple_pkg::OP_LOCATE: begin
            cmd.search_lo = P'(1);
            cmd.search_hi = count_ff;
         end
         ple_pkg::OP_PRIOR: begin
            cmd.search_lo = P'(2);
            cmd.search_hi = count_ff;
         end
         ple_pkg::OP_NEXT: begin
            cmd.search_lo = P'(1);
            cmd.search_hi = (count_ff == '0) ? '0 : count_ff - P'(1);
         end
         default: begin
            cmd.search_lo = P'(1);
            cmd.search_hi = '0;
         end
      endcase
   end

   // Row of cells
   for (genvar i = 0; i < N; i++) begin : g_cell
      logic [W-1:0] left_entry;
      logic [W-1:0] right_entry;

      if (i == 0) begin : g_first
         assign left_entry = '0;
      end else begin : g_inner_l
         assign left_entry = cell_entry[i-1];
      end
      if (i == N - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_inner_r
         assign right_entry = cell_entry[i+1];
      end

      ple_cell u_cell (
         .clock       (clock),
         .cell_index  (ple_pkg::IDX_WIDTH'(i)),
         .cmd         (cmd),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .first_hit   (first[i]),
         .entry       (cell_entry[i]),
         .match       (hits[i]),
         .read_tap    (read_tap[i]),
         .near_tap    (near_tap[i]),
         .pos_tap     (pos_tap[i])
      );
   end

   ple_pick u_pick (
      .hits  (hits),
      .first (first)
   );

   // Merge the taps of the row
   always_comb begin
      read_any = '0;
      near_any = '0;
      pos_any  = '0;
      for (int i = 0; i < N; i++) begin
         read_any = read_any | read_tap[i];
         near_any = near_any | near_tap[i];
         pos_any  = pos_any | pos_tap[i];
      end
   end

   // Execute phase: update length, capture read or removed value
   always_comb begin
      count_in = count_ff;
      ok_in    = ok_ff;
      data_in  = data_ff;
      if (exec_phase) begin
         ok_in   = ins_ok || del_ok || rd_ok || (op_ff == ple_pkg::OP_CLEAR);
         data_in = (del_ok || rd_ok) ? read_any : '0;
         if (op_ff == ple_pkg::OP_CLEAR) begin
            count_in = '0;
         end else if (ins_ok) begin
            count_in = count_ff + P'(1);
         end else if (del_ok) begin
            count_in = count_ff - P'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff   <= ok_in;
      data_ff <= data_in;
   end

   // Result phase: form the result
   always_comb begin
      rsp_ok_in    = ok_ff;
      rsp_value_in = data_ff;
      rsp_pos_in   = '0;
      case (op_ff)
         ple_pkg::OP_LOCATE: begin
            rsp_ok_in    = |hits;
            rsp_value_in = '0;
            rsp_pos_in   = pos_any;
         end
         ple_pkg::OP_PRIOR,
         ple_pkg::OP_NEXT: begin
            rsp_ok_in    = |hits;
            rsp_value_in = near_any;
         end
         default: begin
            rsp_ok_in    = ok_ff;
            rsp_value_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= resp_phase;
      end
   end

   always_ff @(posedge clock) begin
      if (resp_phase) begin
         rsp_ok_ff    <= rsp_ok_in;
         rsp_value_ff <= rsp_value_in;
         rsp_pos_ff   <= rsp_pos_in;
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_found_value    = rsp_value_ff;
   assign rsp_found_position = rsp_pos_ff;
   assign rsp_list_length    = count_ff;

   // Checks
   `PLE_ASSERT_NEXT(a_accept_busy, accept, busy && !rsp_strobe, "accept did not start work")
   `PLE_ASSERT_NEXT(a_strobe_single, rsp_strobe, !rsp_strobe, "result strobe held too long")
   `PLE_ASSERT_NOW(a_first_onehot, resp_phase, $onehot0(first), "more than one first match")
   `PLE_ASSERT_NOW(a_length_range, rsp_strobe, count_ff <= P'(N), "length beyond capacity")

endmodule
